/* design/sfpd_pkg.sv */
// Package for the stream first-pattern delete unit.
// Holds bus widths, register indexes and default sizes; depends on nothing.

package sfpd_pkg;

  localparam int MAX_PATTERN_DEFAULT = 8;

  localparam int DATA_W     = 8;
  localparam int PATTERN_W  = 64;
  localparam int LEN_W      = 4;
  localparam int S_TDATA_W  = 8;
  localparam int M_TDATA_W  = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BYTES  = 1'b0,
    CFG_PATTERN_LENGTH = 1'b1
  } cfg_index_t;

endpackage

/* design/stream_first_pattern_delete_unit.sv */
// Top level of the stream first-pattern delete unit.
// Uses sfpd_pkg for widths, register indexes and the default pattern depth.
//
// Channel   Dir  Beat contents (lowest bit first)
// s_*       in   tdata: data_byte[7:0]; tlast: end_of_string
// m_*       out  tdata: out_byte[7:0]; tuser: byte_valid; tlast: final_result
// cfg_*     in   cfg_index selects pattern_bytes (0) or pattern_length (1)
//
// A byte is taken every cycle while each byte yields at most one result and
// the output is not stalled. A byte with more results (end-of-string flush,
// or a shortened pattern) holds off the input while the result buffer drains
// one beat per ready cycle. Reset is synchronous and clears the window state.
// The output register may stall while the next input byte is still accepted.

module stream_first_pattern_delete_unit #(
  parameter int MAX_PATTERN = sfpd_pkg::MAX_PATTERN_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [sfpd_pkg::S_TDATA_W-1:0]  s_tdata,   // data_byte
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [sfpd_pkg::M_TDATA_W-1:0]  m_tdata,   // out_byte
  output logic                            m_tuser,   // byte_valid
  output logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [sfpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfpd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int FW = $clog2(MAX_PATTERN + 1);
  localparam int DW = sfpd_pkg::DATA_W;

  logic [sfpd_pkg::PATTERN_W-1:0] pattern_bytes;
  logic [sfpd_pkg::LEN_W-1:0]     pattern_length;

  logic [DW-1:0] window [MAX_PATTERN];
  logic [FW-1:0] window_fill;
  logic          already_removed;

  logic [DW-1:0] burst_bytes [MAX_PATTERN];
  logic [FW-1:0] burst_count;
  logic          burst_last;
  logic          burst_bare;

  logic [DW-1:0] out_byte;
  logic          out_byte_valid;

  logic [FW-1:0] len_act;
  logic [FW-1:0] total;
  logic [FW-1:0] shift_amt;
  logic          reach;
  logic          match;
  logic          full_match;
  logic [FW-1:0] emit_count;
  logic          emit_bare;
  logic [FW-1:0] window_fill_next;
  logic          already_removed_next;
  logic [DW-1:0] seq_bytes [MAX_PATTERN];
  logic [DW-1:0] shifted [MAX_PATTERN];
  logic [DW-1:0] window_next [MAX_PATTERN];

  logic accept;
  logic move;

  assign move   = (burst_count != '0) && (!m_tvalid || m_tready);
  assign s_tready = (burst_count == '0) || ((burst_count == FW'(1)) && move);
  assign accept = s_tvalid && s_tready;

  always_comb begin
    if (pattern_length == '0) begin
      len_act = FW'(1);
    end else if (pattern_length > sfpd_pkg::LEN_W'(MAX_PATTERN)) begin
      len_act = FW'(MAX_PATTERN);
    end else begin
      len_act = FW'(pattern_length);
    end

    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (i < int'(window_fill)) begin
        seq_bytes[i] = window[i];
      end else begin
        seq_bytes[i] = s_tdata[DW-1:0];
      end
    end

    total     = window_fill + FW'(1);
    reach     = !already_removed && (total >= len_act);
    shift_amt = reach ? (total - len_act) : '0;

    for (int i = 0; i < MAX_PATTERN; i++) begin
      shifted[i] = s_tdata[DW-1:0];
      for (int j = i; j < MAX_PATTERN; j++) begin
        if (int'(shift_amt) == j - i) begin
          shifted[i] = seq_bytes[j];
        end
      end
    end

    match = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (i < int'(len_act) && shifted[i] != pattern_bytes[8*i +: 8]) begin
        match = 1'b0;
      end
    end
    full_match = reach && match;

    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (!reach) begin
        window_next[i] = seq_bytes[i];
      end else if (i + 1 < MAX_PATTERN) begin
        window_next[i] = shifted[i + 1];
      end else begin
        window_next[i] = s_tdata[DW-1:0];
      end
    end

    already_removed_next = already_removed;
    if (already_removed) begin
      emit_count       = FW'(1);
      window_fill_next = '0;
    end else if (!reach) begin
      emit_count       = '0;
      window_fill_next = total;
    end else if (full_match) begin
      emit_count           = shift_amt;
      window_fill_next     = '0;
      already_removed_next = 1'b1;
    end else begin
      emit_count       = shift_amt + FW'(1);
      window_fill_next = len_act - FW'(1);
    end

    if (s_tlast) begin
      if (already_removed) begin
        emit_count = FW'(1);
      end else if (full_match) begin
        emit_count = shift_amt;
      end else begin
        emit_count = total;
      end
      window_fill_next     = '0;
      already_removed_next = 1'b0;
    end

    emit_bare = s_tlast && (emit_count == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= sfpd_pkg::LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        sfpd_pkg::CFG_PATTERN_BYTES: begin
          pattern_bytes <= cfg_data;
        end
        sfpd_pkg::CFG_PATTERN_LENGTH: begin
          pattern_length <= cfg_data[sfpd_pkg::LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill     <= '0;
      already_removed <= 1'b0;
    end else if (accept) begin
      window_fill     <= window_fill_next;
      already_removed <= already_removed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        window[i] <= window_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_count <= '0;
    end else if (accept) begin
      burst_count <= emit_bare ? FW'(1) : emit_count;
    end else if (move) begin
      burst_count <= burst_count - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        burst_bytes[i] <= seq_bytes[i];
      end
      burst_last <= s_tlast;
      burst_bare <= emit_bare;
    end else if (move) begin
      for (int i = 0; i + 1 < MAX_PATTERN; i++) begin
        burst_bytes[i] <= burst_bytes[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_byte       <= burst_bare ? '0 : burst_bytes[0];
      out_byte_valid <= !burst_bare;
      m_tlast        <= burst_last && (burst_count == FW'(1));
    end
  end

  assign m_tdata = out_byte;
  assign m_tuser = out_byte_valid;

  // The input is only taken once the buffered results are drained or leaving.
  a_accept_drained: assert property (@(posedge clk) disable iff (rst)
    accept |-> (burst_count <= FW'(1)))
    else $error("byte accepted while results still buffered");

  // The window never holds a full pattern between bytes.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    window_fill < FW'(MAX_PATTERN))
    else $error("window fill reached pattern depth");

  // After the deletion the window stays empty.
  a_removed_empty: assert property (@(posedge clk) disable iff (rst)
    already_removed |-> (window_fill == '0))
    else $error("window holds bytes after deletion");

  // A bare end marker always closes the string.
  a_bare_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> m_tlast)
    else $error("bare end marker without tlast");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for stream_first_pattern_delete_unit.
// Drives strings through the slave stream, predicts the surviving bytes, and checks
// every master beat in order; depends on sfpd_pkg and the unit itself.

module tb;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       final_result;
  } out_beat_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    sfpd_pkg::cfg_index_t reg_idx;
    logic [63:0]          reg_val;
    logic [7:0]           data;
    logic                 last;
    bit                   typed;
    out_beat_t            want;
  } stim_row_t;

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [sfpd_pkg::S_TDATA_W-1:0]  s_tdata;   // data_byte
  logic                            s_tlast;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [sfpd_pkg::M_TDATA_W-1:0]  m_tdata;   // out_byte
  logic                            m_tuser;   // byte_valid
  logic                            m_tlast;
  logic                            cfg_we;
  sfpd_pkg::cfg_index_t            cfg_index;
  logic [sfpd_pkg::CFG_DATA_W-1:0] cfg_data;

  stream_first_pattern_delete_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  logic [63:0] pat_reg;
  logic [3:0]  len_reg;
  logic [7:0]  win [sfpd_pkg::MAX_PATTERN_DEFAULT];
  int          fill;
  bit          removed;
  out_beat_t   step_res [sfpd_pkg::MAX_PATTERN_DEFAULT];
  int          step_cnt;
  out_beat_t   survivor_q [$];
  stim_row_t   stim_rows [$];
  int          fails;
  bit          quiet_run;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_run || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int eff_len();
    if (len_reg == 4'd0) return 1;
    if (len_reg > sfpd_pkg::MAX_PATTERN_DEFAULT) return sfpd_pkg::MAX_PATTERN_DEFAULT;
    return int'(len_reg);
  endfunction

  function automatic void push_res(input logic [7:0] b, input logic v);
    step_res[step_cnt] = {b, v, 1'b0};
    step_cnt++;
  endfunction

  function automatic void pop_oldest();
    int i;
    push_res(win[0], 1'b1);
    for (i = 1; i < fill; i++) win[i-1] = win[i];
    fill--;
  endfunction

  function automatic void apply_deletion(input logic [7:0] b, input logic l);
    int n;
    int i;
    bit hit;
    n = eff_len();
    step_cnt = 0;
    if (removed) begin
      push_res(b, 1'b1);
    end else begin
      if (fill >= sfpd_pkg::MAX_PATTERN_DEFAULT) pop_oldest();
      win[fill % sfpd_pkg::MAX_PATTERN_DEFAULT] = b;
      fill++;
      while (fill > n) pop_oldest();
      if (fill == n) begin
        hit = 1'b1;
        for (i = 0; i < n; i++) if (win[i] != pat_reg[8*i +: 8]) hit = 1'b0;
        if (hit) begin
          fill = 0;
          removed = 1'b1;
        end else begin
          pop_oldest();
        end
      end
    end
    if (l) begin
      while (fill > 0) pop_oldest();
      if (step_cnt == 0) push_res(8'h00, 1'b0);
      step_res[step_cnt-1].final_result = 1'b1;
      fill = 0;
      removed = 1'b0;
    end
  endfunction

  function automatic void record(input logic [7:0] b, input logic l, input bit typed,
                                 input out_beat_t want);
    int i;
    apply_deletion(b, l);
    if (typed) begin
      survivor_q.push_back(want);
    end else begin
      for (i = 0; i < step_cnt; i++) survivor_q.push_back(step_res[i]);
    end
  endfunction

  function automatic void add_byte(input logic [7:0] b, input logic l, input bit typed = 1'b0,
                                   input out_beat_t want = '0);
    stim_row_t row;
    row.kind = ROW_BYTE;
    row.reg_idx = sfpd_pkg::CFG_PATTERN_BYTES;
    row.reg_val = '0;
    row.data = b;
    row.last = l;
    row.typed = typed;
    row.want = want;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input sfpd_pkg::cfg_index_t idx, input logic [63:0] val);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    row.data = '0;
    row.last = 1'b0;
    row.typed = 1'b0;
    row.want = '0;
    stim_rows.push_back(row);
  endfunction

  task automatic drive_byte(input logic [7:0] b, input logic l);
    int g;
    g = pick_gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (survivor_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input sfpd_pkg::cfg_index_t idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == sfpd_pkg::CFG_PATTERN_BYTES) pat_reg = val;
    else len_reg = val[3:0];
  endtask

  initial begin
    out_beat_t w;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      int g;
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        if (survivor_q.size() == 0) begin
          $error("unexpected beat: out_byte %h, byte_valid %b, final_result %b",
                 m_tdata[7:0], m_tuser, m_tlast);
          fails++;
        end else begin
          w = survivor_q.pop_front();
          if (m_tdata[7:0] !== w.out_byte) begin
            $error("out_byte: expected %h, got %h", w.out_byte, m_tdata[7:0]);
            fails++;
          end
          if (m_tuser !== w.byte_valid) begin
            $error("byte_valid: expected %b, got %b", w.byte_valid, m_tuser);
            fails++;
          end
          if (m_tlast !== w.final_result) begin
            $error("final_result: expected %b, got %b", w.final_result, m_tlast);
            fails++;
          end
        end
      end
      g = pick_gap();
      m_tready <= (g == 0);
      if (g > 1) begin
        repeat (g - 1) begin
          @(posedge clk);
          if (m_tvalid && m_tready) begin
            $error("beat taken while stalled");
            fails++;
          end
        end
      end
    end
  end

  initial begin
    stim_row_t   row;
    logic [7:0]  str_q [$];
    logic [63:0] val;
    int          items_done;
    int          target;
    int          n;
    int          r;
    int          cut;
    int          mid_at;
    int          i;
    int          j;
    bit          noisy;

    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = sfpd_pkg::CFG_PATTERN_BYTES;
    cfg_data  = '0;
    pat_reg   = '0;
    len_reg   = 4'd1;
    fill      = 0;
    removed   = 1'b0;
    fails     = 0;
    quiet_run = 1'b0;
    items_done = 0;
    for (i = 0; i < sfpd_pkg::MAX_PATTERN_DEFAULT; i++) win[i] = '0;

    // Reset pattern is a single zero byte, so a lone zero deletes the whole string.
    add_byte(8'h00, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1});
    add_byte(8'hFF, 1'b1, 1'b1, {8'hFF, 1'b1, 1'b1});
    add_cfg(sfpd_pkg::CFG_PATTERN_LENGTH, 64'd0);
    add_byte(8'h00, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1});
    add_cfg(sfpd_pkg::CFG_PATTERN_BYTES, 64'h0000_0000_0063_6261);
    add_cfg(sfpd_pkg::CFG_PATTERN_LENGTH, 64'd3);
    add_byte(8'h61, 1'b0);
    add_byte(8'h62, 1'b0);
    add_byte(8'h61, 1'b0);
    add_byte(8'h62, 1'b0);
    add_byte(8'h63, 1'b0);
    add_byte(8'h61, 1'b0);
    add_byte(8'h62, 1'b0);
    add_byte(8'h63, 1'b1);
    add_cfg(sfpd_pkg::CFG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cfg(sfpd_pkg::CFG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
    for (i = 0; i < 8; i++) add_byte(8'hFF, i == 7);
    for (i = 0; i < 5; i++) add_byte(8'h61, 1'b0);
    // Shorten the pattern and change its bytes while five bytes sit in the window.
    add_cfg(sfpd_pkg::CFG_PATTERN_BYTES, 64'h0000_0000_0000_6161);
    add_cfg(sfpd_pkg::CFG_PATTERN_LENGTH, 64'd2);
    add_byte(8'h61, 1'b1);

    wait (rst === 1'b0);
    @(posedge clk);

    for (i = 0; i < stim_rows.size(); i++) begin
      row = stim_rows[i];
      if (row.kind == ROW_CFG) begin
        if (i == 0 || stim_rows[i-1].kind != ROW_CFG) wait_quiet();
        write_reg(row.reg_idx, row.reg_val);
        if (i + 1 == stim_rows.size() || stim_rows[i+1].kind != ROW_CFG) cfg_we <= 1'b0;
      end else begin
        drive_byte(row.data, row.last);
        record(row.data, row.last, row.typed, row.want);
      end
    end

    while (items_done < 320) begin
      if (items_done == 0 || $urandom_range(0, 3) == 0) begin
        wait_quiet();
        r = $urandom_range(0, 9);
        if (r < 4) begin
          for (i = 0; i < 8; i++) val[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 2));
        end else if (r < 8) begin
          val = {$urandom, $urandom};
        end else if (r == 8) begin
          val = '0;
        end else begin
          val = '1;
        end
        write_reg(sfpd_pkg::CFG_PATTERN_BYTES, val);
        val = {$urandom, $urandom};
        val[3:0] = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(1, 8))
                                              : 4'($urandom_range(0, 15));
        write_reg(sfpd_pkg::CFG_PATTERN_LENGTH, val);
        cfg_we <= 1'b0;
      end
      quiet_run = ($urandom_range(0, 5) == 0);
      n = eff_len();
      target = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      noisy = ($urandom_range(0, 4) == 0);
      str_q.delete();
      while (str_q.size() < target) begin
        r = $urandom_range(0, 9);
        if (noisy || r == 9) begin
          str_q.push_back(8'($urandom));
        end else if (r < 3) begin
          for (i = 0; i < n; i++) str_q.push_back(pat_reg[8*i +: 8]);
        end else if (r < 5) begin
          cut = $urandom_range(1, n);
          for (i = 0; i < cut; i++) str_q.push_back(pat_reg[8*i +: 8]);
        end else begin
          str_q.push_back(pat_reg[8*$urandom_range(0, n-1) +: 8]);
        end
      end
      while (str_q.size() > target) void'(str_q.pop_back());
      mid_at = (target >= 2 && $urandom_range(0, 7) == 0) ? $urandom_range(1, target - 1) : -1;

      for (j = 0; j < target; j++) begin
        if (j == mid_at) begin
          wait_quiet();
          if ($urandom_range(0, 1) == 0) begin
            write_reg(sfpd_pkg::CFG_PATTERN_BYTES, {$urandom, $urandom});
          end
          write_reg(sfpd_pkg::CFG_PATTERN_LENGTH, 64'($urandom_range(0, 15)));
          cfg_we <= 1'b0;
        end
        drive_byte(str_q[j], j == target - 1);
        record(str_q[j], j == target - 1, 1'b0, '0);
        items_done++;
      end
    end

    quiet_run = 1'b0;
    s_tvalid <= 1'b0;
    while (survivor_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
